// File: rtl/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types, constants and the direction code function for the chain code
// packer.
// ----------------------------------------------------------------------------
package pcc_pkg;

    // Field widths of the packed stream.
    localparam int BYTE_W       = 8;
    localparam int NIBBLE_W     = 4;
    localparam int HDR_W        = 32;
    localparam int HEADER_BYTES = 8;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Byte index within one command: header plus end byte is nine bytes.
    localparam int IDX_W        = 4;

    localparam logic [NIBBLE_W-1:0] END_NIBBLE = 4'hF;

    // One classified point, as handed from the front to the back.
    typedef struct packed {
        logic                is_header;
        logic [HDR_W-1:0]    hdr_x;
        logic [HDR_W-1:0]    hdr_y;
        logic [NIBBLE_W-1:0] code;
        logic                bad;
        logic                last;
    } pcc_cmd_t;

    // Queue status seen by the front.
    typedef struct packed {
        logic full;
        logic empty;
    } pcc_qstat_t;

    // Direction code from the offsets dx+1 and dy+1, each in 0..2.
    function automatic logic [NIBBLE_W-1:0] dir_code(input logic [1:0] dxo,
                                                     input logic [1:0] dyo);
        logic [NIBBLE_W-1:0] raw;
        raw = {1'b0, dxo, 1'b0} + {2'b00, dxo} + {2'b00, dyo};
        return (raw > 4'd4) ? (raw - 4'd1) : raw;
    endfunction

endpackage

// File: rtl/pcc_if.sv
// ----------------------------------------------------------------------------
// pcc_if
// Valid/ready channels for path points and for packed stream bytes.
// ----------------------------------------------------------------------------
interface pcc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic        path_end;

    modport source (output valid, output coord_x, output coord_y, output path_end,
                    input ready);
    modport sink (input valid, input coord_x, input coord_y, input path_end,
                  output ready);
endinterface

interface pcc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       path_done;
    logic       bad_move;

    modport source (output valid, output out_byte, output run_last, output path_done,
                    output bad_move, input ready);
    modport sink (input valid, input out_byte, input run_last, input path_done,
                  input bad_move, output ready);
endinterface

// File: rtl/path_chain_code_packer.sv
// ----------------------------------------------------------------------------
// path_chain_code_packer
// Packs a stream of path points into an 8-direction chain code byte stream.
// ----------------------------------------------------------------------------
// The front takes one point per cycle while the four-entry command queue has
// room; the back emits at most one byte per cycle, while the receiver is
// ready, from a registered output stage. A step point yields at most two
// bytes; the first point of a path yields eight header bytes, or nine when it
// is also the final point. Sustained input rate over steps is one point per
// cycle while the receiver is ready, set by the back end's one byte per cycle.
module path_chain_code_packer
    import pcc_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    pcc_in_if.sink    point,
    pcc_out_if.source stream
);

    pcc_qstat_t qstat;
    logic       push;
    pcc_cmd_t   push_cmd;
    logic       pop;
    pcc_cmd_t   head;
    logic       head_valid;

    pcc_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .point (point),
        .qstat (qstat),
        .push  (push),
        .cmd   (push_cmd)
    );

    pcc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .qstat      (qstat)
    );

    pcc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .stream     (stream)
    );

endmodule

// File: rtl/pcc_front.sv
// ----------------------------------------------------------------------------
// pcc_front
// Accepts path points, tracks the previous point and classifies each point as
// a header or a step with its direction code.
// ----------------------------------------------------------------------------
module pcc_front
    import pcc_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    pcc_in_if.sink     point,
    input  pcc_qstat_t qstat,
    output logic       push,
    output pcc_cmd_t   cmd
);

    localparam int DW = COORD_WIDTH + 1;

    logic                   in_path_reg;
    logic                   in_path_next;
    logic [COORD_WIDTH-1:0] prev_x_reg;
    logic [COORD_WIDTH-1:0] prev_y_reg;
    logic [COORD_WIDTH-1:0] x_cw;
    logic [COORD_WIDTH-1:0] y_cw;
    logic signed [DW-1:0]   dx;
    logic signed [DW-1:0]   dy;
    logic                   near_x;
    logic                   near_y;
    logic                   adjacent;

    // A beat is taken whenever the queue has room.
    assign point.ready = !qstat.full;
    assign push        = point.valid && point.ready;

    assign x_cw = point.coord_x[COORD_WIDTH-1:0];
    assign y_cw = point.coord_y[COORD_WIDTH-1:0];

    // Exact step from the previous point, one bit wider than the coordinates.
    assign dx = DW'($signed(x_cw)) - DW'($signed(prev_x_reg));
    assign dy = DW'($signed(y_cw)) - DW'($signed(prev_y_reg));

    assign near_x   = (dx == '0) || (dx == DW'(1)) || (dx == '1);
    assign near_y   = (dy == '0) || (dy == DW'(1)) || (dy == '1);
    assign adjacent = near_x && near_y && !((dx == '0) && (dy == '0));

    // Command for the back end.
    always_comb
    begin
        cmd.is_header = !in_path_reg;
        cmd.hdr_x     = HDR_W'($signed(x_cw));
        cmd.hdr_y     = HDR_W'($signed(y_cw));
        cmd.code      = adjacent ? dir_code(dx[1:0] + 2'b01, dy[1:0] + 2'b01) : END_NIBBLE;
        cmd.bad       = !adjacent;
        cmd.last      = point.path_end;
    end

    // Path tracking: the point after a final point opens a new path.
    assign in_path_next = push ? !point.path_end : in_path_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_path_reg <= 1'b0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
        end
        else
        begin
            in_path_reg <= in_path_next;
            if (push)
            begin
                prev_x_reg <= x_cw;
                prev_y_reg <= y_cw;
            end
        end
    end

endmodule

// File: rtl/pcc_queue.sv
// ----------------------------------------------------------------------------
// pcc_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module pcc_queue
    import pcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  pcc_cmd_t   push_cmd,
    input  logic       pop,
    output pcc_cmd_t   head,
    output logic       head_valid,
    output pcc_qstat_t qstat
);

    pcc_cmd_t           mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign head       = mem[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign qstat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // Fill level.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

endmodule

// File: rtl/pcc_back.sv
// ----------------------------------------------------------------------------
// pcc_back
// Expands queued commands into bytes: header bytes, packed direction nibbles
// and the end mark, through a registered output stage.
// ----------------------------------------------------------------------------
module pcc_back
    import pcc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  pcc_cmd_t head,
    input  logic     head_valid,
    output logic     pop,
    pcc_out_if.source stream
);

    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;
    logic                pend_reg;
    logic                pend_next;
    logic [NIBBLE_W-1:0] held_reg;
    logic [NIBBLE_W-1:0] held_next;
    logic                held_bad_reg;
    logic                held_bad_next;

    logic                ovalid_reg;
    logic [BYTE_W-1:0]   obyte_reg;
    logic                olast_reg;
    logic                odone_reg;
    logic                obad_reg;

    logic [IDX_W-1:0]    n_bytes;
    logic [BYTE_W-1:0]   cur_byte;
    logic                cur_done;
    logic                cur_bad;
    logic                cur_final;
    logic                slot_free;
    logic                fire;
    logic [HDR_W-1:0]    hdr_word;

    // Number of bytes the head command produces.
    always_comb
    begin
        if (head.is_header)
        begin
            n_bytes = IDX_W'(HEADER_BYTES) + IDX_W'(head.last);
        end
        else
        begin
            n_bytes = IDX_W'(pend_reg) + IDX_W'(head.last);
        end
    end

    assign hdr_word  = idx_reg[2] ? head.hdr_y : head.hdr_x;
    assign cur_final = (idx_reg == (n_bytes - IDX_W'(1)));

    // Byte at the current index of the head command.
    always_comb
    begin
        cur_byte = {END_NIBBLE, {NIBBLE_W{1'b0}}};
        cur_done = 1'b1;
        cur_bad  = 1'b0;
        priority if (head.is_header && (idx_reg < IDX_W'(HEADER_BYTES)))
        begin
            cur_byte = hdr_word[{idx_reg[1:0], 3'b000} +: BYTE_W];
            cur_done = 1'b0;
        end
        else if (head.is_header)
        begin
            cur_done = 1'b1;
        end
        else if (pend_reg && (idx_reg == '0))
        begin
            cur_byte = {held_reg, head.code};
            cur_done = 1'b0;
            cur_bad  = held_bad_reg || head.bad;
        end
        else if (pend_reg)
        begin
            cur_done = 1'b1;
        end
        else
        begin
            cur_byte = {head.code, END_NIBBLE};
            cur_bad  = head.bad;
        end
    end

    // Handshake with the output stage and the queue.
    assign slot_free = !ovalid_reg || stream.ready;
    assign fire      = head_valid && (n_bytes != '0) && slot_free;
    assign pop       = head_valid && ((n_bytes == '0) || (fire && cur_final));

    // Nibble state moves on when a command retires; the byte index steps on each byte sent.
    always_comb
    begin
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        held_next     = held_reg;
        held_bad_next = held_bad_reg;
        if (pop)
        begin
            idx_next = '0;
            if (head.is_header || head.last || pend_reg)
            begin
                pend_next     = 1'b0;
                held_next     = '0;
                held_bad_next = 1'b0;
            end
            else
            begin
                pend_next     = 1'b1;
                held_next     = head.code;
                held_bad_next = head.bad;
            end
        end
        else if (fire)
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
            held_reg     <= '0;
            held_bad_reg <= 1'b0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            idx_reg      <= idx_next;
            pend_reg     <= pend_next;
            held_reg     <= held_next;
            held_bad_reg <= held_bad_next;
            if (fire)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (stream.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            obyte_reg <= cur_byte;
            olast_reg <= cur_final;
            odone_reg <= cur_done;
            obad_reg  <= cur_bad;
        end
    end

    assign stream.valid     = ovalid_reg;
    assign stream.out_byte  = obyte_reg;
    assign stream.run_last  = olast_reg;
    assign stream.path_done = odone_reg;
    assign stream.bad_move  = obad_reg;

endmodule

// File: rtl/pcc_checker.sv
// ----------------------------------------------------------------------------
// pcc_checker
// Port-level checks on the packed byte stream.
// ----------------------------------------------------------------------------
module pcc_checker
    import pcc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       path_done,
    input logic       bad_move
);

    // A stalled beat stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    // The end mark always closes the bytes of its point.
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && path_done |-> run_last)
        else $error("end mark not on the last byte of its point");

    // The end mark byte carries an end nibble.
    a_done_nibble: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && path_done |->
            (out_byte[7:4] == END_NIBBLE) || (out_byte[3:0] == END_NIBBLE))
        else $error("end mark byte without end nibble");

    // A bad move is coded as nibble 15 in its byte.
    a_bad_nibble: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_move |->
            (out_byte[7:4] == END_NIBBLE) || (out_byte[3:0] == END_NIBBLE))
        else $error("bad move byte without escape nibble");

endmodule

bind path_chain_code_packer pcc_checker u_pcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (stream.valid),
    .out_ready (stream.ready),
    .out_byte  (stream.out_byte),
    .run_last  (stream.run_last),
    .path_done (stream.path_done),
    .bad_move  (stream.bad_move)
);

// File: tb/sv/pcc_stream_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcc_stream_checker
// Watches the point and stream channels of the chain code packer. It predicts
// the packed byte stream from every accepted point and compares each accepted
// output beat with the oldest expected beat.
// ----------------------------------------------------------------------------
module pcc_stream_checker
    import pcc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    pcc_in_if    point,
    pcc_out_if   stream,
    output int   outstanding,
    output int   mismatches
);

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              run_last;
        logic              path_done;
        logic              bad_move;
    } stream_beat_t;

    // Packer state as the predictor sees it.
    logic [31:0]         last_x;
    logic [31:0]         last_y;
    logic                inside_path;
    logic                half_full;
    logic [NIBBLE_W-1:0] half_nib;
    logic                half_bad;

    // Beats caused by the point being predicted, and all beats still owed.
    stream_beat_t point_beats[$];
    stream_beat_t owed_beats[$];

    // Adds one nibble to the half-built byte; a full byte becomes a beat.
    task automatic add_nibble(input logic [NIBBLE_W-1:0] nib, input logic bad,
                              input logic done);
        if (half_full)
        begin
            point_beats.insert(point_beats.size(),
                               '{data: {half_nib, nib}, run_last: 1'b0,
                                 path_done: done, bad_move: half_bad | bad});
            half_full = 1'b0;
            half_nib  = '0;
            half_bad  = 1'b0;
        end
        else
        begin
            half_nib  = nib;
            half_bad  = bad;
            half_full = 1'b1;
        end
    endtask

    // Works out the beats that one accepted point causes.
    task automatic pack_point(input logic [31:0] x, input logic [31:0] y,
                              input logic last);
        logic signed [32:0]  dx;
        logic signed [32:0]  dy;
        logic [NIBBLE_W-1:0] code;
        int                  raw;
        point_beats.delete();
        if (!inside_path)
        begin
            // The first point goes out whole: x then y, low byte first.
            for (int i = 0; i < HEADER_BYTES / 2; i++)
                point_beats.insert(point_beats.size(),
                                   '{data: x[8*i +: 8], run_last: 1'b0,
                                     path_done: 1'b0, bad_move: 1'b0});
            for (int i = 0; i < HEADER_BYTES / 2; i++)
                point_beats.insert(point_beats.size(),
                                   '{data: y[8*i +: 8], run_last: 1'b0,
                                     path_done: 1'b0, bad_move: 1'b0});
            inside_path = 1'b1;
            half_full   = 1'b0;
            half_nib    = '0;
            half_bad    = 1'b0;
        end
        else
        begin
            // Exact step from the previous point; 33 bits cannot wrap.
            dx = $signed({x[31], x}) - $signed({last_x[31], last_x});
            dy = $signed({y[31], y}) - $signed({last_y[31], last_y});
            if (dx >= -1 && dx <= 1 && dy >= -1 && dy <= 1 && !(dx == 0 && dy == 0))
            begin
                raw  = 3 * (int'(dx) + 1) + int'(dy) + 1;
                code = NIBBLE_W'((raw > 4) ? raw - 1 : raw);
                add_nibble(code, 1'b0, 1'b0);
            end
            else
            begin
                add_nibble(END_NIBBLE, 1'b1, 1'b0);
            end
        end
        last_x = x;
        last_y = y;

        // The final point closes the path with the end nibble.
        if (last)
        begin
            if (half_full)
                add_nibble(END_NIBBLE, 1'b0, 1'b1);
            else
                point_beats.insert(point_beats.size(),
                                   '{data: {END_NIBBLE, NIBBLE_W'(0)}, run_last: 1'b0,
                                     path_done: 1'b1, bad_move: 1'b0});
            inside_path = 1'b0;
            half_full   = 1'b0;
            half_nib    = '0;
            half_bad    = 1'b0;
        end

        if (point_beats.size() > 0)
            point_beats[point_beats.size() - 1].run_last = 1'b1;
        foreach (point_beats[i])
            owed_beats.insert(owed_beats.size(), point_beats[i]);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
        end
    endtask

    // Output beats are checked before the point of the same edge is predicted,
    // so a beat can never be matched against its own point.
    always @(posedge clk or negedge rst_n)
    begin
        stream_beat_t want;
        if (!rst_n)
        begin
            last_x      = '0;
            last_y      = '0;
            inside_path = 1'b0;
            half_full   = 1'b0;
            half_nib    = '0;
            half_bad    = 1'b0;
            mismatches  = 0;
            owed_beats.delete();
            outstanding <= 0;
        end
        else
        begin
            if (stream.valid && stream.ready)
            begin
                if (owed_beats.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: stream beat mismatch, expected none, actual %02h %b%b%b",
                             $time, stream.out_byte, stream.run_last, stream.path_done,
                             stream.bad_move);
                end
                else
                begin
                    want = owed_beats.pop_front();
                    check_field("out_byte", want.data, stream.out_byte);
                    check_field("run_last", 8'(want.run_last), 8'(stream.run_last));
                    check_field("path_done", 8'(want.path_done), 8'(stream.path_done));
                    check_field("bad_move", 8'(want.bad_move), 8'(stream.bad_move));
                end
            end
            if (point.valid && point.ready)
                pack_point(point.coord_x, point.coord_y, point.path_end);
            outstanding <= owed_beats.size();
        end
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the chain code packer. Directed paths cover header
// extremes, all eight directions, broken steps and both end nibble cases;
// random paths follow, with bursty input and a stalling stream receiver.
// ----------------------------------------------------------------------------
module testbench;

    localparam int POINT_TARGET    = 160;
    localparam int IDLE_LIMIT      = 3000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int HOLD_OFF_CYCLES = 200;

    localparam int STEP_DX[8] = '{-1, -1, -1,  0, 0,  1, 1, 1};
    localparam int STEP_DY[8] = '{-1,  0,  1, -1, 1, -1, 0, 1};

    localparam logic [31:0] EDGE_COORDS[4] = '{32'h8000_0000, 32'h7FFF_FFFF,
                                               32'h0000_0000, 32'hFFFF_FFFF};

    logic clk;
    logic rst_n;
    int   outstanding;
    int   mismatches;
    int   points_sent;
    int   burst_left;
    int   idle_cycles;

    pcc_in_if  point ();
    pcc_out_if stream ();

    path_chain_code_packer uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point),
        .stream (stream)
    );

    pcc_stream_checker stream_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .point       (point),
        .stream      (stream),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Offers one point, after a random gap when a burst has run out.
    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                point.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        point.valid    <= 1'b1;
        point.coord_x  <= x;
        point.coord_y  <= y;
        point.path_end <= last;
        @(posedge clk);
        while (!point.ready)
            @(posedge clk);
        points_sent++;
    endtask

    function automatic logic [31:0] pick_coord();
        return ($urandom_range(0, 3) == 0) ? EDGE_COORDS[$urandom_range(0, 3)] : $urandom;
    endfunction

    // One random path: mostly neighbor steps, with some broken steps and
    // some runs of unrelated points.
    task automatic random_path();
        logic [31:0] x;
        logic [31:0] y;
        int          steps;
        int          dir;
        if ($urandom_range(0, 7) == 0)
        begin
            steps = $urandom_range(0, 4);
            for (int k = 0; k <= steps; k++)
                send_point($urandom, $urandom, k == steps);
        end
        else
        begin
            x = pick_coord();
            y = pick_coord();
            steps = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 14);
            send_point(x, y, steps == 0);
            for (int k = 1; k <= steps; k++)
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    // Broken step: a stay, a two-cell jump or a leap.
                    case ($urandom_range(0, 2))
                        0: ;
                        1: y = y - 32'd2;
                        default:
                        begin
                            x = $urandom;
                            y = $urandom;
                        end
                    endcase
                end
                else
                begin
                    dir = $urandom_range(0, 7);
                    x = x + STEP_DX[dir];
                    y = y + STEP_DY[dir];
                end
                send_point(x, y, k == steps);
            end
        end
    endtask

    // Watchdog: cycles in which no beat moves on either channel.
    always @(posedge clk)
    begin
        if ((point.valid && point.ready) || (stream.valid && stream.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        idle_cycles = 0;
        wait (idle_cycles >= IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Stream receiver: segments of different stall patterns, and two long
    // hold-offs that let the packer fill up and stall its input.
    initial
    begin : receiver
        int segment;
        int span;
        int mode;
        segment = 0;
        stream.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            segment++;
            if (segment == 8 || segment == 60)
            begin
                stream.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(4, 40);
                repeat (span)
                begin
                    case (mode)
                        0:       stream.ready <= 1'b1;
                        1:       stream.ready <= 1'($urandom_range(0, 1));
                        2:       stream.ready <= ($urandom_range(0, 7) != 0);
                        default: stream.ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [31:0] x;
        logic [31:0] y;
        burst_left     = 0;
        points_sent    = 0;
        rst_n          <= 1'b0;
        point.valid    <= 1'b0;
        point.coord_x  <= '0;
        point.coord_y  <= '0;
        point.path_end <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A path of one point: header and a lone end byte.
        send_point(32'h0, 32'h0, 1'b1);

        // Header at the extremes, then every direction near the top and
        // bottom of the coordinate range.
        x = 32'h7FFF_FFFF;
        y = 32'h8000_0000;
        send_point(x, y, 1'b0);
        x = x - 32'd1;
        y = y + 32'd1;
        send_point(x, y, 1'b0);
        for (int d = 0; d < 8; d++)
        begin
            x = x + STEP_DX[d];
            y = y + STEP_DY[d];
            send_point(x, y, 1'b0);
        end

        // Broken steps: no move, a two-cell jump, and a jump across the
        // signed range that must not wrap around.
        send_point(x, y, 1'b0);
        x = x + 32'd2;
        send_point(x, y, 1'b0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);

        // One step then end: the end nibble completes the held byte.
        send_point(32'd5, -32'sd7, 1'b0);
        send_point(32'd6, -32'sd8, 1'b1);

        // Two steps then end: the end nibble starts a byte of its own.
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_point(32'h0, 32'hFFFF_FFFF, 1'b0);
        send_point(32'h0, 32'h0, 1'b1);

        while (points_sent < POINT_TARGET)
            random_path();
        point.valid <= 1'b0;

        // Wait for every owed beat, then for any stray ones.
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: path_chain_code_packer.f
rtl/pcc_pkg.sv
rtl/pcc_if.sv
rtl/pcc_front.sv
rtl/pcc_queue.sv
rtl/pcc_back.sv
rtl/path_chain_code_packer.sv
rtl/pcc_checker.sv
tb/sv/pcc_stream_checker.sv
tb/sv/testbench.sv
